### src/lbfb_pkg.sv
// ----------------------------------------------------------------------------
// lbfb_pkg: shared types and constants for the LED bar frame builder
// Holds the payload structs, the request and register codes, the graduated
// brightness curve and the microcode table that drives the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbfb_pkg;

    localparam int SEG_COUNT   = 10;
    localparam int FRAME_WORDS = SEG_COUNT + 3;
    localparam int SEG_W       = $clog2(SEG_COUNT);
    localparam int CNT_W       = $clog2(FRAME_WORDS);
    localparam int CFG_IDX_W   = 2;

    localparam logic [SEG_W-1:0] LAST_SEG  = SEG_W'(SEG_COUNT - 1);
    localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(FRAME_WORDS - 1);
    localparam logic [7:0]       FULL_ON   = 8'd255;

    // Request codes.
    localparam logic [2:0] REQ_SET_LEVEL = 3'd0;
    localparam logic [2:0] REQ_SET_ONE   = 3'd1;
    localparam logic [2:0] REQ_SET_ALL   = 3'd2;
    localparam logic [2:0] REQ_CLEAR     = 3'd3;
    localparam logic [2:0] REQ_SHOW      = 3'd4;
    localparam logic [2:0] REQ_REAPPLY   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRADUATED = CFG_IDX_W'(1);

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] bar_level;
        logic [7:0] segment_index;
        logic [7:0] segment_value;
    } req_t;

    typedef struct packed {
        logic [15:0] frame_word;
        logic        frame_last;
    } frame_t;

    // Microprogram addresses.
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_LVL_IN,
        STEP_LVL_LOOP,
        STEP_ONE,
        STEP_ALL,
        STEP_CLEAR,
        STEP_REAPPLY,
        STEP_EMIT
    } step_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_LEVEL,
        WR_ONE,
        WR_ALL_VAL,
        WR_ALL_ZERO
    } wr_sel_t;

    typedef enum logic [1:0] {
        LVL_KEEP,
        LVL_INPUT,
        LVL_ZERO
    } lvl_sel_t;

    typedef enum logic [1:0] {
        SEQ_JUMP,
        SEQ_DISPATCH,
        SEQ_SEG_LOOP,
        SEQ_EMIT
    } seq_t;

    typedef struct packed {
        logic     in_ready;
        wr_sel_t  wr;
        lvl_sel_t lvl;
        seq_t     seq;
        step_t    target;
    } ucode_t;

    // Graduated curve: percent * 255 / 100, truncated.
    function automatic logic [7:0] curve_value(logic [SEG_W-1:0] seg);
        logic [7:0] v;
        case (seg)
            SEG_W'(0): v = 8'd12;
            SEG_W'(1): v = 8'd25;
            SEG_W'(2): v = 8'd51;
            SEG_W'(3): v = 8'd76;
            SEG_W'(4): v = 8'd102;
            SEG_W'(5): v = 8'd127;
            SEG_W'(6): v = 8'd153;
            SEG_W'(7): v = 8'd178;
            SEG_W'(8): v = 8'd204;
            SEG_W'(9): v = 8'd255;
            default:   v = 8'd0;
        endcase
        return v;
    endfunction

    // Control store: one word per step.
    function automatic ucode_t ucode_rom(step_t s);
        ucode_t u;
        case (s)
            STEP_IDLE:     u = '{in_ready: 1'b1, wr: WR_NONE, lvl: LVL_KEEP,
                                 seq: SEQ_DISPATCH, target: STEP_IDLE};
            STEP_LVL_IN:   u = '{in_ready: 1'b0, wr: WR_NONE, lvl: LVL_INPUT,
                                 seq: SEQ_JUMP, target: STEP_LVL_LOOP};
            STEP_LVL_LOOP: u = '{in_ready: 1'b0, wr: WR_LEVEL, lvl: LVL_KEEP,
                                 seq: SEQ_SEG_LOOP, target: STEP_EMIT};
            STEP_ONE:      u = '{in_ready: 1'b0, wr: WR_ONE, lvl: LVL_KEEP,
                                 seq: SEQ_JUMP, target: STEP_EMIT};
            STEP_ALL:      u = '{in_ready: 1'b0, wr: WR_ALL_VAL, lvl: LVL_KEEP,
                                 seq: SEQ_JUMP, target: STEP_EMIT};
            STEP_CLEAR:    u = '{in_ready: 1'b0, wr: WR_ALL_ZERO, lvl: LVL_ZERO,
                                 seq: SEQ_JUMP, target: STEP_EMIT};
            STEP_REAPPLY:  u = '{in_ready: 1'b0, wr: WR_NONE, lvl: LVL_KEEP,
                                 seq: SEQ_JUMP, target: STEP_LVL_LOOP};
            STEP_EMIT:     u = '{in_ready: 1'b0, wr: WR_NONE, lvl: LVL_KEEP,
                                 seq: SEQ_EMIT, target: STEP_IDLE};
            default:       u = '{in_ready: 1'b0, wr: WR_NONE, lvl: LVL_KEEP,
                                 seq: SEQ_JUMP, target: STEP_IDLE};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

### src/led_bar_frame_builder.sv
// ----------------------------------------------------------------------------
// led_bar_frame_builder: ten-segment LED bar frame builder
// A microcoded sequencer updates ten channel brightness registers per command
// and streams a 13-word frame for the LED driver.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on req (req_valid/req_ready). Every command except an
// out-of-range set_one and the unused codes produces one frame of 13
// transactions on frame (frame_valid/frame_ready): a zero command word, the
// ten channel values with channel 0 first, and two zero words, the last one
// flagged with frame_last. Register writes arrive on cfg (cfg_valid, always
// ready) and only change reverse_order or graduated_mode.
// Sequence: show goes straight to the emit step; set_one, set_all and clear
// pass through their write step first; set_level passes through the level
// input step and reapply through the reapply step, and both then run the
// level loop, which writes one segment a cycle through all ten segments,
// before the emit step. Ignored commands return straight to idle.
// The emit step issues one word per cycle into a single output register, so
// a stalled receiver holds the sequencer on that step. The last word can
// wait in the output register while the next command is accepted.
// Reset clears all channels and the stored level, sets reverse_order to 1
// and graduated_mode to 0; the block is ready in the first cycle after it.
// ----------------------------------------------------------------------------
`default_nettype none

module led_bar_frame_builder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire lbfb_pkg::req_t                 req,
    output logic                                frame_valid,
    input  wire logic                           frame_ready,
    output lbfb_pkg::frame_t                    frame,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lbfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                           cfg_data
);

    lbfb_pkg::step_t              pc_reg, pc_next;
    logic [lbfb_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    lbfb_pkg::req_t               req_reg;
    logic [lbfb_pkg::SEG_W-1:0]   level_reg, level_next;
    logic [7:0]                   ch_reg  [lbfb_pkg::SEG_COUNT];
    logic [7:0]                   ch_next [lbfb_pkg::SEG_COUNT];
    logic                         reverse_reg;
    logic                         graduated_reg;
    logic                         frame_valid_reg;
    lbfb_pkg::frame_t             frame_reg;

    lbfb_pkg::ucode_t             uw;
    logic                         req_fire;
    logic                         frame_load;
    logic [lbfb_pkg::SEG_W-1:0]   wr_seg;
    logic [lbfb_pkg::SEG_W-1:0]   wr_chan;
    logic [7:0]                   level_val;
    lbfb_pkg::frame_t             word_next;
    logic [lbfb_pkg::SEG_W-1:0]   rd_chan;

    assign cfg_ready   = 1'b1;
    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    always_comb
    begin
        uw         = lbfb_pkg::ucode_rom(pc_reg);
        req_ready  = uw.in_ready;
        req_fire   = req_valid && uw.in_ready;
        frame_load = (uw.seq == lbfb_pkg::SEQ_EMIT) && (!frame_valid_reg || frame_ready);
    end

    // Sequencer: next step and shared segment/word counter.
    always_comb
    begin
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        case (uw.seq)
            lbfb_pkg::SEQ_DISPATCH:
            begin
                cnt_next = '0;
                if (req_fire)
                begin
                    case (req.req_type)
                        lbfb_pkg::REQ_SET_LEVEL: pc_next = lbfb_pkg::STEP_LVL_IN;
                        lbfb_pkg::REQ_SET_ONE:
                            pc_next = (req.segment_index < 8'(lbfb_pkg::SEG_COUNT))
                                      ? lbfb_pkg::STEP_ONE : lbfb_pkg::STEP_IDLE;
                        lbfb_pkg::REQ_SET_ALL:   pc_next = lbfb_pkg::STEP_ALL;
                        lbfb_pkg::REQ_CLEAR:     pc_next = lbfb_pkg::STEP_CLEAR;
                        lbfb_pkg::REQ_SHOW:      pc_next = lbfb_pkg::STEP_EMIT;
                        lbfb_pkg::REQ_REAPPLY:   pc_next = lbfb_pkg::STEP_REAPPLY;
                        default:                 pc_next = lbfb_pkg::STEP_IDLE;
                    endcase
                end
            end
            lbfb_pkg::SEQ_SEG_LOOP:
            begin
                if (cnt_reg == lbfb_pkg::CNT_W'(lbfb_pkg::LAST_SEG))
                begin
                    cnt_next = '0;
                    pc_next  = uw.target;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lbfb_pkg::SEQ_EMIT:
            begin
                if (frame_load)
                begin
                    if (cnt_reg == lbfb_pkg::LAST_WORD)
                    begin
                        cnt_next = '0;
                        pc_next  = uw.target;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                pc_next = uw.target;
            end
        endcase
    end

    // Stored level.
    always_comb
    begin
        case (uw.lvl)
            lbfb_pkg::LVL_INPUT:
                level_next = (req_reg.bar_level > 8'(lbfb_pkg::SEG_COUNT))
                             ? lbfb_pkg::SEG_W'(lbfb_pkg::SEG_COUNT)
                             : req_reg.bar_level[lbfb_pkg::SEG_W-1:0];
            lbfb_pkg::LVL_ZERO: level_next = '0;
            default:            level_next = level_reg;
        endcase
    end

    // Channel write path.
    always_comb
    begin
        wr_seg = (uw.wr == lbfb_pkg::WR_ONE) ? req_reg.segment_index[lbfb_pkg::SEG_W-1:0]
                                             : cnt_reg[lbfb_pkg::SEG_W-1:0];
        wr_chan = reverse_reg ? (lbfb_pkg::LAST_SEG - wr_seg) : wr_seg;
        if (cnt_reg[lbfb_pkg::SEG_W-1:0] < level_reg)
        begin
            level_val = graduated_reg ? lbfb_pkg::curve_value(cnt_reg[lbfb_pkg::SEG_W-1:0])
                                      : lbfb_pkg::FULL_ON;
        end
        else
        begin
            level_val = 8'd0;
        end
        for (int c = 0; c < lbfb_pkg::SEG_COUNT; c++)
        begin
            ch_next[c] = ch_reg[c];
            case (uw.wr)
                lbfb_pkg::WR_LEVEL:
                    if (wr_chan == lbfb_pkg::SEG_W'(c)) ch_next[c] = level_val;
                lbfb_pkg::WR_ONE:
                    if (wr_chan == lbfb_pkg::SEG_W'(c)) ch_next[c] = req_reg.segment_value;
                lbfb_pkg::WR_ALL_VAL:  ch_next[c] = req_reg.segment_value;
                lbfb_pkg::WR_ALL_ZERO: ch_next[c] = 8'd0;
                default:               ch_next[c] = ch_reg[c];
            endcase
        end
    end

    // Frame word for the current emit position.
    always_comb
    begin
        rd_chan   = lbfb_pkg::SEG_W'(cnt_reg - 1'b1);
        word_next = '0;
        if (cnt_reg >= lbfb_pkg::CNT_W'(1) && cnt_reg <= lbfb_pkg::CNT_W'(lbfb_pkg::SEG_COUNT))
        begin
            word_next.frame_word = {8'd0, ch_reg[rd_chan]};
        end
        word_next.frame_last = (cnt_reg == lbfb_pkg::LAST_WORD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= lbfb_pkg::STEP_IDLE;
            cnt_reg         <= '0;
            level_reg       <= '0;
            reverse_reg     <= 1'b1;
            graduated_reg   <= 1'b0;
            frame_valid_reg <= 1'b0;
            for (int c = 0; c < lbfb_pkg::SEG_COUNT; c++)
            begin
                ch_reg[c] <= 8'd0;
            end
        end
        else
        begin
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            level_reg <= level_next;
            for (int c = 0; c < lbfb_pkg::SEG_COUNT; c++)
            begin
                ch_reg[c] <= ch_next[c];
            end
            if (cfg_valid && cfg_index == lbfb_pkg::CFG_REVERSE)
            begin
                reverse_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == lbfb_pkg::CFG_GRADUATED)
            begin
                graduated_reg <= cfg_data;
            end
            if (frame_load)
            begin
                frame_valid_reg <= 1'b1;
            end
            else if (frame_ready)
            begin
                frame_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        if (frame_load)
        begin
            frame_reg <= word_next;
        end
    end

    // The stored level never exceeds the segment count.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= lbfb_pkg::SEG_W'(lbfb_pkg::SEG_COUNT))
        else $error("stored level out of range");

    // The counter is always clear while waiting for a command.
    a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == lbfb_pkg::STEP_IDLE) |-> (cnt_reg == '0))
        else $error("counter not clear in idle step");

    // Loading the last word of a frame returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_load && cnt_reg == lbfb_pkg::LAST_WORD)
        |=> (pc_reg == lbfb_pkg::STEP_IDLE && frame_valid_reg && frame_reg.frame_last))
        else $error("frame end did not return to idle");

    // The flagged word of a frame is a zero trailer word.
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid_reg && frame_reg.frame_last) |-> (frame_reg.frame_word == 16'd0))
        else $error("last frame word not zero");

endmodule

`default_nettype wire
